// ----- hdl/mvcr_pkg.sv -----
// Shared constants, codes and types for the mesh vertex compaction remap block.
package mvcr_pkg;

  localparam int MAX_VERTICES = 65536;
  localparam int IDX_W        = 16;
  localparam int STORE_DEPTH  = 2 ** IDX_W;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W        = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

  localparam int ADDR_W = 2;
  localparam int DATA_W = 32;

  localparam logic [ADDR_W-1:0] REG_KEEP_VALUE = '0;
  localparam logic              KEEP_VALUE_RST = 1'b1;

  localparam logic [1:0] OP_START    = 2'd0;
  localparam logic [1:0] OP_VERTEX   = 2'd1;
  localparam logic [1:0] OP_TRIANGLE = 2'd2;

  localparam logic [1:0] KIND_START    = 2'd0;
  localparam logic [1:0] KIND_VERTEX   = 2'd1;
  localparam logic [1:0] KIND_TRIANGLE = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  typedef struct packed {
    logic             keep;
    logic [IDX_W-1:0] new_idx;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             kept;
    logic [IDX_W-1:0] old_index;
    logic [IDX_W-1:0] new_a;
    logic [IDX_W-1:0] new_b;
    logic [IDX_W-1:0] new_c;
  } result_t;

endpackage

// ----- hdl/mvcr_if.sv -----
// Item and result channel interfaces.
interface mvcr_item_if;
  import mvcr_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic             vertex_flag;
  logic [IDX_W-1:0] corner_a;
  logic [IDX_W-1:0] corner_b;
  logic [IDX_W-1:0] corner_c;

  modport source (output valid, opcode, vertex_flag, corner_a, corner_b, corner_c,
                  input ready);
  modport sink (input valid, opcode, vertex_flag, corner_a, corner_b, corner_c,
                output ready);
endinterface

interface mvcr_result_if;
  import mvcr_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic             kept;
  logic [IDX_W-1:0] old_index;
  logic [IDX_W-1:0] new_a;
  logic [IDX_W-1:0] new_b;
  logic [IDX_W-1:0] new_c;

  modport source (output valid, kind, kept, old_index, new_a, new_b, new_c,
                  input ready);
  modport sink (input valid, kind, kept, old_index, new_a, new_b, new_c,
                output ready);
endinterface

// ----- hdl/mvcr_store.sv -----
// Vertex table: keep bit and new index per old index, one write and one read port.
module mvcr_store (
  input  logic                 clk,
  input  mvcr_pkg::store_req_t req,
  output mvcr_pkg::entry_t     rdata
);
  import mvcr_pkg::*;

  entry_t mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- hdl/mvcr_cfg.sv -----
// APB register block holding keep_value.
module mvcr_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mvcr_pkg::ADDR_W-1:0] paddr,
  input  logic [mvcr_pkg::DATA_W-1:0] pwdata,
  output logic [mvcr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic                        keep_value
);
  import mvcr_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_value <= KEEP_VALUE_RST;
    end else if (wr_en && (paddr == REG_KEEP_VALUE)) begin
      keep_value <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr)
      REG_KEEP_VALUE: prdata = DATA_W'(keep_value);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- hdl/mvcr_ctrl.sv -----
// Item sequencer: counters, table access, triangle reads and two-entry result buffer.
module mvcr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 keep_value,
  mvcr_item_if.sink            items,
  mvcr_result_if.source        results,
  output mvcr_pkg::store_req_t req,
  input  mvcr_pkg::entry_t     rdata
);
  import mvcr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RD_B  = 4'b0010,
    ST_RD_C  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] vertex_count, kept_count;
  logic [IDX_W-1:0] corner_b, corner_c;
  logic             tri_keep;
  logic [IDX_W-1:0] remap_a, remap_b;
  logic             ov, hv;
  result_t          od, hd;
  result_t          res;
  logic             res_valid;
  logic             accept, pop;
  logic [CMP_W-1:0] pos_ext;
  logic             vflow, in_store, keep_now, corner_bad, tri_kept;

  assign accept   = items.valid && items.ready;
  assign pop      = ov && results.ready;
  assign pos_ext  = CMP_W'(vertex_count);
  assign vflow    = pos_ext >= CMP_W'(MAX_VERTICES);
  assign in_store = pos_ext < CMP_W'(STORE_DEPTH);
  assign keep_now = items.vertex_flag == keep_value;
  assign corner_bad = (CMP_W'(items.corner_a) >= pos_ext) ||
                      (CMP_W'(items.corner_b) >= pos_ext) ||
                      (CMP_W'(items.corner_c) >= pos_ext);
  assign tri_kept = tri_keep && rdata.keep;

  assign items.ready = (state == ST_IDLE) && !hv;

  always_comb begin
    state_next         = state;
    res                = '0;
    res_valid          = 1'b0;
    req.we             = 1'b0;
    req.waddr          = IDX_W'(pos_ext);
    req.wdata.keep     = keep_now;
    req.wdata.new_idx  = keep_now ? IDX_W'(kept_count) : '0;
    req.raddr          = items.corner_a;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (items.opcode)
            OP_START: begin
              res.kind  = KIND_START;
              res_valid = 1'b1;
            end
            OP_VERTEX: begin
              res_valid = 1'b1;
              if (vflow) begin
                res.kind = KIND_ERROR;
              end else begin
                res.kind      = KIND_VERTEX;
                res.kept      = keep_now;
                res.old_index = IDX_W'(pos_ext);
                res.new_a     = keep_now ? IDX_W'(kept_count) : '0;
                req.we        = in_store;
              end
            end
            OP_TRIANGLE: begin
              if (corner_bad) begin
                res.kind  = KIND_ERROR;
                res_valid = 1'b1;
              end else begin
                state_next = ST_RD_B;
              end
            end
            default: begin
              res.kind  = KIND_ERROR;
              res_valid = 1'b1;
            end
          endcase
        end
      end
      ST_RD_B: begin
        req.raddr  = corner_b;
        state_next = ST_RD_C;
      end
      ST_RD_C: begin
        req.raddr  = corner_c;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        res.kind  = KIND_TRIANGLE;
        res.kept  = tri_kept;
        if (tri_kept) begin
          res.new_a = remap_a;
          res.new_b = remap_b;
          res.new_c = rdata.new_idx;
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= '0;
      kept_count   <= '0;
      ov           <= 1'b0;
      hv           <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (items.opcode == OP_START)) begin
        vertex_count <= '0;
        kept_count   <= '0;
      end else if (accept && (items.opcode == OP_VERTEX) && !vflow) begin
        vertex_count <= vertex_count + CNT_W'(1);
        kept_count   <= kept_count + CNT_W'(keep_now);
      end
      if (pop) begin
        if (hv) begin
          hv <= res_valid;
        end else begin
          ov <= res_valid;
        end
      end else if (res_valid) begin
        if (ov) begin
          hv <= 1'b1;
        end else begin
          ov <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      corner_b <= items.corner_b;
      corner_c <= items.corner_c;
    end
    if (state == ST_RD_B) begin
      tri_keep <= rdata.keep;
      remap_a  <= rdata.new_idx;
    end
    if (state == ST_RD_C) begin
      tri_keep <= tri_keep && rdata.keep;
      remap_b  <= rdata.new_idx;
    end
    if (pop) begin
      if (hv) begin
        od <= hd;
        hd <= res;
      end else begin
        od <= res;
      end
    end else if (res_valid) begin
      if (ov) begin
        hd <= res;
      end else begin
        od <= res;
      end
    end
  end

  assign results.valid     = ov;
  assign results.kind      = od.kind;
  assign results.kept      = od.kept;
  assign results.old_index = od.old_index;
  assign results.new_a     = od.new_a;
  assign results.new_b     = od.new_b;
  assign results.new_c     = od.new_c;

endmodule

// ----- hdl/mesh_vertex_compaction_remap.sv -----
// Top level of the mesh vertex compaction and index remap block.
// Start and vertex results form in the accepting cycle; a triangle beat steps
// through ST_RD_B, ST_RD_C and ST_DONE, its three corners read in turn through the
// single read port of the vertex table (one read a cycle, registered read data),
// the result formed in ST_DONE. Every accepted beat yields exactly one result beat;
// a two-entry output buffer lets a new item in while a result waits. The table has
// no reset and needs no clearing pass: a corner is only looked up when it is below
// the current vertex count, so its entry was written this mesh.
module mesh_vertex_compaction_remap (
  input  logic                        clk,
  input  logic                        rst,
  mvcr_item_if.sink                   items,
  mvcr_result_if.source               results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mvcr_pkg::ADDR_W-1:0] paddr,
  input  logic [mvcr_pkg::DATA_W-1:0] pwdata,
  output logic [mvcr_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import mvcr_pkg::*;

  logic       keep_value;
  store_req_t req;
  entry_t     rdata;

  mvcr_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .keep_value (keep_value)
  );

  mvcr_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  mvcr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .keep_value (keep_value),
    .items      (items),
    .results    (results),
    .req        (req),
    .rdata      (rdata)
  );

endmodule

// ----- hdl/mvcr_chk.sv -----
// Port-level checker for the mesh vertex compaction remap block, with its bind.
module mvcr_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  in_opcode,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  kind,
  input logic                        kept,
  input logic [mvcr_pkg::IDX_W-1:0]  old_index,
  input logic [mvcr_pkg::IDX_W-1:0]  new_a,
  input logic [mvcr_pkg::IDX_W-1:0]  new_b,
  input logic [mvcr_pkg::IDX_W-1:0]  new_c
);
  import mvcr_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_start_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_opcode == OP_START) |=> out_valid)
    else $error("start beat produced no pending result");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_ERROR) |->
      !kept && (old_index == '0) && (new_a == '0) && (new_b == '0) && (new_c == '0))
    else $error("error result carries nonzero fields");

  a_drop_tri_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_TRIANGLE) && !kept |->
      (old_index == '0) && (new_a == '0) && (new_b == '0) && (new_c == '0))
    else $error("dropped triangle carries corner indices");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(kept) &&
      $stable(old_index) && $stable(new_a) && $stable(new_b) && $stable(new_c))
    else $error("stalled result beat changed");

endmodule

bind mesh_vertex_compaction_remap mvcr_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_opcode (items.opcode),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .kind      (results.kind),
  .kept      (results.kept),
  .old_index (results.old_index),
  .new_a     (results.new_a),
  .new_b     (results.new_b),
  .new_c     (results.new_c)
);
